// ----- hw/rtl/vtdc_pkg.sv -----
// Shared types, constants and the arctangent table of the drive command pipeline.
package vtdc_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEER_STEPS  = 15;
  localparam logic signed [15:0] STEER_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    REG_SPEED_LIMIT    = 2'd0,
    REG_THROTTLE_LIMIT = 2'd1,
    REG_AXLE_DISTANCE  = 2'd2,
    REG_STEER_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] yaw_rate;
  } in_t;

  typedef struct packed {
    logic        [15:0] throttle_level;
    logic               brake_full;
    logic               reverse_gear;
    logic signed [15:0] steer_level;
  } out_t;

  typedef struct packed {
    logic [14:0] speed_limit;
    logic [15:0] throttle_limit;
    logic [14:0] axle_distance;
    logic [14:0] steer_limit;
  } cfg_t;

  // Carried through the CORDIC stages, together with the throttle division.
  typedef struct packed {
    logic               brake;
    logic               rev;
    logic               low;
    logic               wpos;
    logic               yzero;
    logic               tsat;
    logic               tbit;
    logic        [14:0] trem;
    logic        [15:0] tq;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [17:0] z;
  } mid_t;

  // Carried through the steering division stages.
  typedef struct packed {
    logic        [15:0] throttle;
    logic               brake;
    logic               rev;
    logic               low;
    logic               wpos;
    logic               zzero;
    logic               aneg;
    logic               ssat;
    logic        [2:0]  am3;
    logic        [14:0] srem;
    logic        [14:0] sq;
  } sdv_t;

  function automatic logic signed [17:0] atan_at(input int unsigned i);
    logic signed [17:0] r;
    case (i)
      0:       r = 18'sd51472;
      1:       r = 18'sd30386;
      2:       r = 18'sd16055;
      3:       r = 18'sd8150;
      4:       r = 18'sd4091;
      5:       r = 18'sd2047;
      6:       r = 18'sd1024;
      7:       r = 18'sd512;
      8:       r = 18'sd256;
      9:       r = 18'sd128;
      10:      r = 18'sd64;
      11:      r = 18'sd32;
      12:      r = 18'sd16;
      13:      r = 18'sd8;
      14:      r = 18'sd4;
      15:      r = 18'sd2;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // Arithmetic right shift that truncates toward zero.
  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                input int unsigned s);
    logic signed [33:0] r;
    if (v[33]) r = -((-v) >>> s);
    else       r = v >>> s;
    return r;
  endfunction

endpackage

// ----- hw/rtl/velocity_to_drive_command.sv -----
// Top level of the speed and yaw-rate to drive command pipeline.
// This block accepts one command transfer per clock while the output side is not stalled, and
// returns exactly one drive command per input, in order, through these registers: one entry
// stage, sixteen CORDIC vectoring stages (which also produce the throttle quotient one bit
// per stage), one stage that forms the throttle and sets up the steering division, fifteen
// division stages and the output register. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stall holds every item in place.
// Configuration registers take a write in any cycle and are meant to be written while no
// command is in flight.
module velocity_to_drive_command import vtdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;
  logic adv;

  logic [CORDIC_STEPS:0] mv;
  mid_t                  md [CORDIC_STEPS+1];
  logic [STEER_STEPS:0]  sv;
  sdv_t                  sd [STEER_STEPS+1];

  sdv_t sd_nxt;
  logic sv0_r;
  sdv_t sd0_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t out_nxt;

  // The whole pipeline moves when the output register can take a new transfer.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit    <= 15'd512;
      cfg_r.throttle_limit <= 16'd32768;
      cfg_r.axle_distance  <= 15'd735;
      cfg_r.steer_limit    <= 15'd4915;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPEED_LIMIT:    cfg_r.speed_limit    <= cfg_data[14:0];
        REG_THROTTLE_LIMIT: cfg_r.throttle_limit <= cfg_data;
        REG_AXLE_DISTANCE:  cfg_r.axle_distance  <= cfg_data[14:0];
        REG_STEER_LIMIT:    cfg_r.steer_limit    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  vtdc_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vin(in_valid && in_ready), .din(in_data),
    .cfg(cfg_r), .vout_r(mv[0]), .dout_r(md[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    vtdc_cordic_stage #(.STEP(i)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .vin(mv[i]), .din(md[i]),
      .speed_limit(cfg_r.speed_limit), .vout_r(mv[i+1]), .dout_r(md[i+1])
    );
  end

  // Throttle selection and steering division set-up. A zero angle (zero wheelbase
  // product) is forced here; the angle magnitude is below 2^17.
  logic signed [17:0] ang;
  logic        [16:0] am;

  always_comb begin
    ang = md[CORDIC_STEPS].yzero ? 18'sd0 : md[CORDIC_STEPS].z;
    am  = ang[17] ? 17'(-ang) : ang[16:0];
    sd_nxt = '0;
    if (md[CORDIC_STEPS].brake) begin
      sd_nxt.throttle = 16'd0;
    end else if (md[CORDIC_STEPS].tsat ||
                 md[CORDIC_STEPS].tq >= cfg_r.throttle_limit) begin
      sd_nxt.throttle = cfg_r.throttle_limit;
    end else begin
      sd_nxt.throttle = md[CORDIC_STEPS].tq;
    end
    sd_nxt.brake = md[CORDIC_STEPS].brake;
    sd_nxt.rev   = md[CORDIC_STEPS].rev;
    sd_nxt.low   = md[CORDIC_STEPS].low;
    sd_nxt.wpos  = md[CORDIC_STEPS].wpos;
    sd_nxt.zzero = (ang == 18'sd0);
    sd_nxt.aneg  = ang[17];
    // A quotient of 2^15 or more always clamps to full steer.
    sd_nxt.ssat  = ({1'b0, am} >= {cfg_r.steer_limit, 3'd0});
    sd_nxt.am3   = am[2:0];
    sd_nxt.srem  = {1'b0, am[16:3]};
    sd_nxt.sq    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv0_r <= 1'b0;
    end else if (adv) begin
      sv0_r <= mv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd0_r <= sd_nxt;
    end
  end

  assign sv[0] = sv0_r;
  assign sd[0] = sd0_r;

  for (genvar j = 0; j < STEER_STEPS; j++) begin : g_div
    vtdc_div_stage #(.STEP(j)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .vin(sv[j]), .din(sd[j]),
      .steer_limit(cfg_r.steer_limit), .vout_r(sv[j+1]), .dout_r(sd[j+1])
    );
  end

  // Output formatting: low speed steers fully towards the yaw rate, otherwise the
  // clamped, normalised angle is negated.
  logic [14:0] qm;

  always_comb begin
    if (sd[STEER_STEPS].ssat || sd[STEER_STEPS].sq > 15'd16384) qm = 15'd16384;
    else                                                        qm = sd[STEER_STEPS].sq;
    out_nxt.throttle_level = sd[STEER_STEPS].throttle;
    out_nxt.brake_full     = sd[STEER_STEPS].brake;
    out_nxt.reverse_gear   = sd[STEER_STEPS].rev;
    if (sd[STEER_STEPS].low) begin
      out_nxt.steer_level = sd[STEER_STEPS].wpos ? STEER_ONE : -STEER_ONE;
    end else if (sd[STEER_STEPS].zzero) begin
      out_nxt.steer_level = 16'sd0;
    end else if (sd[STEER_STEPS].aneg) begin
      out_nxt.steer_level = $signed({1'b0, qm});
    end else begin
      out_nxt.steer_level = -$signed({1'b0, qm});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv[STEER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

// ----- hw/rtl/vtdc_front.sv -----
// Entry stage: magnitude, flags, wheelbase product and division set-up.
module vtdc_front import vtdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic vin,
  input  in_t  din,
  input  cfg_t cfg,
  output logic vout_r,
  output mid_t dout_r
);

  mid_t               dout_nxt;
  logic        [15:0] mag;
  logic signed [31:0] prod;

  always_comb begin
    mag  = din.linear_speed[15] ? 16'(-din.linear_speed) : din.linear_speed;
    prod = $signed({1'b0, cfg.axle_distance}) * din.yaw_rate;
    dout_nxt       = '0;
    dout_nxt.brake = (din.linear_speed == 16'sd0);
    dout_nxt.rev   = din.linear_speed[15];
    dout_nxt.low   = (mag <= 16'd2);
    dout_nxt.wpos  = (din.yaw_rate > 16'sd0);
    dout_nxt.yzero = (prod == 32'sd0);
    dout_nxt.tsat  = ({1'b0, mag} >= {1'b0, cfg.speed_limit, 1'b0});
    dout_nxt.tbit  = mag[0];
    dout_nxt.trem  = mag[15:1];
    dout_nxt.x     = $signed({6'd0, mag, 12'd0});
    dout_nxt.y     = din.linear_speed[15] ? -34'(prod) : 34'(prod);
    dout_nxt.z     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (adv) begin
      vout_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout_r <= dout_nxt;
    end
  end

endmodule

// ----- hw/rtl/vtdc_cordic_stage.sv -----
// One CORDIC vectoring iteration plus one throttle quotient bit.
module vtdc_cordic_stage import vtdc_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        vin,
  input  mid_t        din,
  input  logic [14:0] speed_limit,
  output logic        vout_r,
  output mid_t        dout_r
);

  localparam logic signed [17:0] ATAN = atan_at(STEP);

  mid_t               dout_nxt;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic        [15:0] rem2;

  always_comb begin
    xs = shr_tz(din.x, STEP);
    ys = shr_tz(din.y, STEP);
    dout_nxt = din;
    if (din.y > 34'sd0) begin
      dout_nxt.x = din.x + ys;
      dout_nxt.y = din.y - xs;
      dout_nxt.z = din.z + ATAN;
    end else begin
      dout_nxt.x = din.x - ys;
      dout_nxt.y = din.y + xs;
      dout_nxt.z = din.z - ATAN;
    end
    rem2 = {din.trem, (STEP == 0) ? din.tbit : 1'b0};
    if (rem2 >= {1'b0, speed_limit}) begin
      dout_nxt.trem = 15'(rem2 - {1'b0, speed_limit});
      dout_nxt.tq   = {din.tq[14:0], 1'b1};
    end else begin
      dout_nxt.trem = rem2[14:0];
      dout_nxt.tq   = {din.tq[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (adv) begin
      vout_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout_r <= dout_nxt;
    end
  end

endmodule

// ----- hw/rtl/vtdc_div_stage.sv -----
// One restoring-division step of the steering normalisation.
module vtdc_div_stage import vtdc_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        vin,
  input  sdv_t        din,
  input  logic [14:0] steer_limit,
  output logic        vout_r,
  output sdv_t        dout_r
);

  localparam int K = 14 - int'(STEP);

  sdv_t        dout_nxt;
  logic        in_bit;
  logic [15:0] rem2;

  if (K >= 12) begin : g_bit
    assign in_bit = din.am3[K-12];
  end else begin : g_zero
    assign in_bit = 1'b0;
  end

  always_comb begin
    dout_nxt = din;
    rem2 = {din.srem, in_bit};
    if (rem2 >= {1'b0, steer_limit}) begin
      dout_nxt.srem = 15'(rem2 - {1'b0, steer_limit});
      dout_nxt.sq   = {din.sq[13:0], 1'b1};
    end else begin
      dout_nxt.srem = rem2[14:0];
      dout_nxt.sq   = {din.sq[13:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (adv) begin
      vout_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout_r <= dout_nxt;
    end
  end

endmodule

// ----- hw/rtl/vtdc_checker.sv -----
// Port-level checks on the drive command block, bound to its top level.
module vtdc_checker import vtdc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_brake_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brake_full |-> out_data.throttle_level == 16'd0)
    else $error("throttle while braking");

  a_brake_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brake_full |-> !out_data.reverse_gear)
    else $error("reverse while braking");

  a_steer_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.steer_level <= STEER_ONE && out_data.steer_level >= -STEER_ONE)
    else $error("steering out of range");

endmodule

bind velocity_to_drive_command vtdc_checker u_vtdc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

// ----- sim/tb_velocity_to_drive_command.sv -----
// Self-checking testbench for the speed and yaw-rate to drive command pipeline.
module tb_velocity_to_drive_command;
  import vtdc_pkg::*;

  // Ports of the block. Every input is given a known value at time zero.
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_t      in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_t     out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  reg_idx_t cfg_index = REG_SPEED_LIMIT;
  logic [15:0] cfg_data = '0;

  // This margin lets the pipeline drain before a register write.
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  // The testbench keeps its own copy of the four registers.
  logic [14:0] mdl_speed_limit;
  logic [15:0] mdl_throttle_limit;
  logic [14:0] mdl_axle;
  logic [14:0] mdl_steer_limit;

  out_t expected_cmds[$];
  int   mismatches = 0;
  int   cmds_sent = 0;
  int   cmds_checked = 0;
  int   cfg_writes = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;      // no idling on either side in the last part of the run
  bit   sink_stall = 1'b0; // the receiver's current stall burst

  // The atan table in units of 2^-16 rad, one entry per vectoring step.
  localparam longint ATAN_LUT[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2};

  initial begin
    forever #6 clk = ~clk;
  end

  // The run is ended here if something hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint trunc_shift(longint v, int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  // Works out the drive command that the block should give for one command.
  function automatic out_t drive_command(in_t cmd);
    out_t   r;
    longint v, w, mag, q, x, y, z, xs, ys, am, qm, s;
    v = cmd.linear_speed;
    w = cmd.yaw_rate;
    mag = (v < 0) ? -v : v;
    r = '0;
    if (v == 0) begin
      r.brake_full = 1'b1;
    end else begin
      r.reverse_gear = (v < 0);
      if (mdl_speed_limit == 0) q = mdl_throttle_limit;
      else q = (mag <<< 15) / mdl_speed_limit;
      r.throttle_level = (q < mdl_throttle_limit) ? q[15:0] : mdl_throttle_limit;
    end
    if (mag > 2) begin
      x = mag * 4096;
      y = longint'(mdl_axle) * w;
      if (v < 0) y = -y;
      z = 0;
      // Vectoring mode rotates the vector onto the x axis and sums the angle.
      if (y != 0) begin
        for (int i = 0; i < 16; i++) begin
          xs = trunc_shift(x, i);
          ys = trunc_shift(y, i);
          if (y > 0) begin
            x = x + ys; y = y - xs; z = z + ATAN_LUT[i];
          end else begin
            x = x - ys; y = y + xs; z = z - ATAN_LUT[i];
          end
        end
      end
      if (z == 0) begin
        s = 0;
      end else if (mdl_steer_limit == 0) begin
        s = (z > 0) ? 16384 : -16384;
      end else begin
        am = (z < 0) ? -z : z;
        qm = (am * 4096) / mdl_steer_limit;
        if (qm > 16384) qm = 16384;
        s = (z < 0) ? -qm : qm;
      end
      r.steer_level = -s;
    end else begin
      // Below the speed threshold the steering goes full scale with the yaw rate.
      r.steer_level = (w > 0) ? STEER_ONE : -STEER_ONE;
    end
    return r;
  endfunction

  // Receiver: random stall bursts, and a field-by-field check of every transfer.
  initial begin : sink
    int burst;
    forever begin
      @(negedge clk);
      if (!quiet && !sink_stall && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 16);
        sink_stall = 1'b1;
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
        sink_stall = 1'b0;
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected drive command %h", out_data);
      end else begin
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (want.throttle_level !== out_data.throttle_level ||
            want.brake_full !== out_data.brake_full ||
            want.reverse_gear !== out_data.reverse_gear ||
            want.steer_level !== out_data.steer_level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp thr=%0d brk=%0b rev=%0b str=%0d, got thr=%0d brk=%0b rev=%0b str=%0d",
                     want.throttle_level, want.brake_full, want.reverse_gear,
                     want.steer_level, out_data.throttle_level, out_data.brake_full,
                     out_data.reverse_gear, out_data.steer_level);
        end
      end
    end
  end

  // Sends one command; the expectation is queued at the edge of the transfer.
  // Valid is left high so that commands can follow back to back; an idle gap or
  // a drain takes it low.
  task automatic send_cmd(logic signed [15:0] speed, logic signed [15:0] yaw);
    in_t cmd;
    cmd.linear_speed = speed;
    cmd.yaw_rate = yaw;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    expected_cmds.push_back(drive_command(cmd));
    cmds_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected command has come back and the pipeline is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes one register while no command is in flight.
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPEED_LIMIT:    mdl_speed_limit = value[14:0];
      REG_THROTTLE_LIMIT: mdl_throttle_limit = value;
      REG_AXLE_DISTANCE:  mdl_axle = value[14:0];
      REG_STEER_LIMIT:    mdl_steer_limit = value[14:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] spd, logic [15:0] thr, logic [15:0] axl,
                          logic [15:0] str);
    wait_drained();
    write_reg(REG_SPEED_LIMIT, spd);
    write_reg(REG_THROTTLE_LIMIT, thr);
    write_reg(REG_AXLE_DISTANCE, axl);
    write_reg(REG_STEER_LIMIT, str);
    cfg_valid <= 1'b0;
  endtask

  // Extremes of both fields, zero and threshold speeds, and zero yaw rate.
  task automatic test_directed();
    send_cmd(16'sd0, 16'sd0);
    send_cmd(16'sd0, 16'sd100);
    send_cmd(16'sd0, -16'sd100);
    send_cmd(16'sd2, 16'sd5);
    send_cmd(-16'sd2, -16'sd5);
    send_cmd(16'sd3, 16'sd5);
    send_cmd(-16'sd3, 16'sd5);
    send_cmd(16'sd1000, 16'sd0);
    send_cmd(-16'sd1000, 16'sd0);
    send_cmd(16'sh7fff, 16'sh7fff);
    send_cmd(16'sh7fff, -16'sh8000);
    send_cmd(-16'sh8000, 16'sh7fff);
    send_cmd(-16'sh8000, -16'sh8000);
    send_cmd(16'sd256, 16'sd4096);
    send_cmd(-16'sd256, 16'sd4096);
    send_cmd(16'sd512, -16'sd2048);
    send_cmd(16'sd3, 16'sh7fff);
    send_cmd(16'sd1, -16'sd1);
  endtask

  // Random commands, with small speeds and yaw rates weighted in.
  task automatic test_random(int count);
    logic signed [15:0] spd, yaw;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: spd = $signed(16'($urandom_range(0, 8))) - 16'sd4;
        1: spd = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
        default: spd = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: yaw = '0;
        1: yaw = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
        default: yaw = 16'($urandom);
      endcase
      send_cmd(spd, yaw);
    end
  endtask

  // The register settings in turn, the extremes and the zero values among them.
  task automatic test_register_sweep();
    set_regs(16'd1, 16'd32768, 16'd32767, 16'd1);
    test_directed();
    test_random(150);
    set_regs(16'd32767, 16'd0, 16'd1, 16'd25736);
    test_random(150);
    set_regs(16'd0, 16'd20000, 16'd0, 16'd0);
    test_directed();
    test_random(150);
    set_regs(16'hffff, 16'hffff, 16'h8123, 16'h7fff);
    test_random(150);
    set_regs(16'($urandom_range(1, 32767)), 16'($urandom_range(0, 32768)),
             16'($urandom_range(1, 32767)), 16'($urandom_range(1, 25736)));
    test_random(150);
  endtask

  initial begin
    mdl_speed_limit = 15'd512;
    mdl_throttle_limit = 16'd32768;
    mdl_axle = 15'd735;
    mdl_steer_limit = 15'd4915;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(200);
    // Hold the sender back until every command so far has come back.
    wait_drained();
    test_register_sweep();
    set_regs(16'd512, 16'd32768, 16'd735, 16'd4915);
    quiet = 1'b1;
    test_random(250);

    wait_drained();
    $display("Covered %0d commands under %0d register writes, %0d results checked.",
             cmds_sent, cfg_writes, cmds_checked);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches counted.", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  velocity_to_drive_command u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- files.f -----
hw/rtl/vtdc_pkg.sv
hw/rtl/vtdc_front.sv
hw/rtl/vtdc_cordic_stage.sv
hw/rtl/vtdc_div_stage.sv
hw/rtl/velocity_to_drive_command.sv
hw/rtl/vtdc_checker.sv
sim/tb_velocity_to_drive_command.sv
